/* src/line_aware_receive_fifo_unit_assert.svh */
`ifndef LINE_AWARE_RECEIVE_FIFO_UNIT_ASSERT_SVH
`define LINE_AWARE_RECEIVE_FIFO_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LARF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define LARF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/larf_pkg.sv */
package larf_pkg;

    localparam int DEPTH  = 4096;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam int FUNC_W  = 3;
    localparam int BYTE_W  = 8;
    localparam int FILL_W  = 13;
    localparam int LINE_W  = 13;
    localparam int DCNT_W  = 16;

    localparam logic [FUNC_W-1:0] FUNC_PUSH  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_DATA  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_LINE  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_RESET = 3'd4;

    localparam logic [BYTE_W-1:0] BYTE_LF = 8'd10;
    localparam logic [BYTE_W-1:0] BYTE_CR = 8'd13;

    localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};

    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 56;

    typedef struct packed {
        logic load_item;
        logic exec;
        logic finish;
    } larf_cmd_t;

    typedef struct packed {
        logic pop_hit;
    } larf_stat_t;

    typedef struct packed {
        logic              in_data_mode;
        logic [DCNT_W-1:0] data_count;
        logic [LINE_W-1:0] line_count;
        logic [FILL_W-1:0] fill_level;
        logic              dropped;
        logic              was_empty;
        logic [BYTE_W-1:0] read_byte;
    } larf_result_t;

endpackage

/* src/larf_ctrl.sv */
module larf_ctrl
    import larf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  larf_stat_t stat,
    output larf_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FETCH,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   s_tready_reg, s_tready_next;
    logic   m_tvalid_reg, m_tvalid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
                // a pop that hits data goes through ST_FETCH for the memory read
                state_next = stat.pop_hit ? ST_FETCH : ST_OUT;
            end
            ST_FETCH: begin
                cmd.finish = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        s_tready_next = (state_next == ST_IDLE);
        m_tvalid_next = (state_next == ST_OUT);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            s_tready_reg <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            s_tready_reg <= s_tready_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = s_tready_reg;
    assign m_tvalid = m_tvalid_reg;

endmodule

/* src/larf_datapath.sv */
module larf_datapath
    import larf_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [FUNC_W-1:0]  func,
    input  logic [BYTE_W-1:0]  rx_byte,
    input  larf_cmd_t          cmd,
    output larf_stat_t         stat,
    output larf_result_t       result
);

    logic [BYTE_W-1:0] mem [DEPTH];

    logic [FUNC_W-1:0] func_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] rdata_reg;
    larf_result_t      result_reg, result_next;

    logic [ADDR_W-1:0] wp_reg, wp_next;
    logic [ADDR_W-1:0] rp_reg, rp_next;
    logic [CNT_W-1:0]  held_reg, held_next;
    logic [LINE_W-1:0] lf_reg, lf_next;
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;
    logic              mode_reg, mode_next;

    logic mem_we;
    logic mem_re;
    logic full;
    logic empty;
    logic load_res;

    function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] p);
        ptr_inc = (p == ADDR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full  = (held_reg == CNT_W'(DEPTH));
    assign empty = (held_reg == '0);
    assign stat.pop_hit = (func_reg == FUNC_POP) && !empty;

    always_comb begin
        wp_next   = wp_reg;
        rp_next   = rp_reg;
        held_next = held_reg;
        lf_next   = lf_reg;
        dcnt_next = dcnt_reg;
        mode_next = mode_reg;
        mem_we    = 1'b0;
        mem_re    = 1'b0;

        if (cmd.exec) begin
            case (func_reg)
                FUNC_PUSH: begin
                    if (!full) begin
                        // carriage returns are discarded in line mode
                        if (mode_reg || byte_reg != BYTE_CR) begin
                            mem_we    = 1'b1;
                            wp_next   = ptr_inc(wp_reg);
                            held_next = held_reg + 1'b1;
                            dcnt_next = dcnt_reg + 1'b1;
                        end
                        if (!mode_reg && byte_reg == BYTE_LF && lf_reg != LINE_MAX) begin
                            lf_next = lf_reg + 1'b1;
                        end
                    end
                end
                FUNC_POP: begin
                    if (!empty) begin
                        mem_re    = 1'b1;
                        rp_next   = ptr_inc(rp_reg);
                        held_next = held_reg - 1'b1;
                    end
                end
                FUNC_DATA: begin
                    mode_next = 1'b1;
                    dcnt_next = '0;
                end
                FUNC_LINE: begin
                    mode_next = 1'b0;
                    wp_next   = '0;
                    rp_next   = '0;
                    held_next = '0;
                    lf_next   = '0;
                end
                FUNC_RESET: begin
                    mode_next = 1'b0;
                    wp_next   = '0;
                    rp_next   = '0;
                    held_next = '0;
                    lf_next   = '0;
                    dcnt_next = '0;
                end
                default: begin
                end
            endcase
        end

        // pop counters settle once the byte is back from memory
        if (cmd.finish) begin
            if (mode_reg) begin
                dcnt_next = dcnt_reg - 1'b1;
            end else if (rdata_reg == BYTE_LF && lf_reg != '0) begin
                lf_next = lf_reg - 1'b1;
            end
        end

        load_res = (cmd.exec && !stat.pop_hit) || cmd.finish;

        result_next.read_byte    = cmd.finish ? rdata_reg : '0;
        result_next.was_empty    = cmd.exec && (func_reg == FUNC_POP) && empty;
        result_next.dropped      = cmd.exec && (func_reg == FUNC_PUSH) && full;
        result_next.fill_level   = FILL_W'(held_next);
        result_next.line_count   = lf_next;
        result_next.data_count   = dcnt_next;
        result_next.in_data_mode = mode_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wp_reg] <= byte_reg;
        end
        if (mem_re) begin
            rdata_reg <= mem[rp_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            func_reg <= func;
            byte_reg <= rx_byte;
        end
        if (load_res) begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg   <= '0;
            rp_reg   <= '0;
            held_reg <= '0;
            lf_reg   <= '0;
            dcnt_reg <= '0;
            mode_reg <= 1'b0;
        end else begin
            wp_reg   <= wp_next;
            rp_reg   <= rp_next;
            held_reg <= held_next;
            lf_reg   <= lf_next;
            dcnt_reg <= dcnt_next;
            mode_reg <= mode_next;
        end
    end

    assign result = result_reg;

endmodule

/* src/line_aware_receive_fifo_unit.sv */
// Byte receive FIFO with line awareness, 4096 bytes deep.
// Slave channel: one operation per transaction (push, pop, enter data mode,
// enter line mode, reset). Master channel: exactly one result transaction per
// operation, carrying the popped byte, empty/drop flags and the counters
// (fill level, line feed count, data byte count, mode) after the operation.
// An operation is taken while s_tready is high; the result shows on m_tvalid
// after ST_EXEC, or after ST_EXEC and ST_FETCH for a pop that returns a byte,
// since the byte store is a single memory with a registered read port.
// Operations are handled one at a time: s_tready comes back the cycle after
// the result transaction completes, so no new operation is taken before the
// last one's result has been taken.
// While m_tready is low the result holds and no new operation is taken.
// Reset (aresetn low) empties the FIFO, clears all counters and selects line
// mode; the byte store itself is not cleared and needs no clearing pass, so
// the block is ready the cycle after reset is released.
module line_aware_receive_fifo_unit
    import larf_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // [2:0] func, [10:3] rx_byte, [15:11] zero
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // [7:0] read_byte, [8] was_empty, [9] dropped, [22:10] fill_level,
    // [35:23] line_count, [51:36] data_count, [52] in_data_mode, [55:53] zero
    output logic [M_DATA_W-1:0] m_tdata
);

    larf_cmd_t    cmd;
    larf_stat_t   stat;
    larf_result_t result;

    larf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    larf_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .func    (s_tdata[FUNC_W-1:0]),
        .rx_byte (s_tdata[FUNC_W+BYTE_W-1:FUNC_W]),
        .cmd     (cmd),
        .stat    (stat),
        .result  (result)
    );

    assign m_tdata = M_DATA_W'(result);

endmodule

/* src/larf_checker.sv */
`include "line_aware_receive_fifo_unit_assert.svh"

module larf_checker
    import larf_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [S_DATA_W-1:0] s_tdata,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    `LARF_ASSERT_NEXT(a_result_held, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
    `LARF_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready, "second operation taken while one is in flight")
    `LARF_ASSERT_NOW(a_no_overlap, aclk, aresetn, m_tvalid, !s_tready, "operation taken while a result waits")
    `LARF_ASSERT_NOW(a_flags_exclusive, aclk, aresetn, m_tvalid, !(m_tdata[8] && m_tdata[9]), "empty and drop flagged together")
    `LARF_ASSERT_NOW(a_empty_pop, aclk, aresetn, m_tvalid && m_tdata[8], m_tdata[7:0] == 8'd0 && m_tdata[22:10] == 13'd0, "empty pop returned data or nonzero fill")

endmodule

bind line_aware_receive_fifo_unit larf_checker u_larf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
